// ===== sv/ddrh_pkg.sv =====
// ----------------------------------------------------------------------------
// ddrh_pkg
// Shared types and constants for the differential-drive ramp / H-bridge core.
// ----------------------------------------------------------------------------
package ddrh_pkg;

  // Fixed-point format of the velocity inputs
  localparam int FRAC_BITS = 12;
  localparam int DUTY_BITS = 8;

  // Field widths
  localparam int VEL_W   = 16;
  localparam int GAIN_W  = 10;
  localparam int STEP_W  = 8;
  localparam int LIM_W   = 8;
  localparam int CNT_W   = 16;
  localparam int SPEED_W = 9;

  // Mixer arithmetic: 16b signed x 11b signed product, one bit of growth for the sum
  localparam int PROD_W = VEL_W + GAIN_W + 1;
  localparam int SUM_W  = PROD_W + 1;
  // Ramp arithmetic: speed plus one step, with sign
  localparam int RAMP_W = SPEED_W + 2;

  // Stream payload widths
  localparam int IN_TDATA_W  = 2 * VEL_W;
  localparam int OUT_BITS    = 4 * DUTY_BITS + 2 * SPEED_W + 1;
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  // Register file
  localparam int ADDR_W   = 5;
  localparam int DATA_W   = 32;
  localparam int REG_IDX_W = 3;

  localparam logic [REG_IDX_W-1:0] REG_LINEAR_GAIN   = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_ANGULAR_GAIN  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_RAMP_STEP     = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_SPEED_LIMIT   = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_BRAKE_DUTY    = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_TIMEOUT_TICKS = 3'd5;

  localparam logic [GAIN_W-1:0]    RST_LINEAR_GAIN   = 10'd510;
  localparam logic [GAIN_W-1:0]    RST_ANGULAR_GAIN  = 10'd255;
  localparam logic [STEP_W-1:0]    RST_RAMP_STEP     = 8'd20;
  localparam logic [LIM_W-1:0]     RST_SPEED_LIMIT   = 8'd200;
  localparam logic [DUTY_BITS-1:0] RST_BRAKE_DUTY    = 8'd255;
  localparam logic [CNT_W-1:0]     RST_TIMEOUT_TICKS = 16'd100;

  // Item kinds on the input tuser bit
  localparam logic OP_COMMAND = 1'b0;
  localparam logic OP_TICK    = 1'b1;

  typedef struct packed {
    logic [GAIN_W-1:0]    linear_gain;
    logic [GAIN_W-1:0]    angular_gain;
    logic [STEP_W-1:0]    ramp_step;
    logic [LIM_W-1:0]     speed_limit;
    logic [DUTY_BITS-1:0] brake_duty;
    logic [CNT_W-1:0]     timeout_ticks;
  } cfg_t;

endpackage

// ===== sv/ddrh_mix.sv =====
// ----------------------------------------------------------------------------
// ddrh_mix
// Mixes linear/angular velocity into left/right wheel targets.
// ----------------------------------------------------------------------------
module ddrh_mix (
  input  logic signed [ddrh_pkg::VEL_W-1:0]   linear_velocity_i,
  input  logic signed [ddrh_pkg::VEL_W-1:0]   angular_velocity_i,
  input  ddrh_pkg::cfg_t                      cfg_i,
  output logic signed [ddrh_pkg::SPEED_W-1:0] left_goal_o,
  output logic signed [ddrh_pkg::SPEED_W-1:0] right_goal_o
);
  import ddrh_pkg::*;

  localparam logic signed [SUM_W-1:0] TRUNC_BIAS = SUM_W'((1 << FRAC_BITS) - 1);

  logic signed [PROD_W-1:0] lin_p, ang_p;
  logic signed [SUM_W-1:0]  diff, summ, lim_s;

  function automatic logic signed [SPEED_W-1:0] to_goal(
    input logic signed [SUM_W-1:0] v,
    input logic signed [SUM_W-1:0] lim
  );
    logic signed [SUM_W-1:0] t, c;
    // magnitude shift: bias negatives so the shift truncates toward zero
    t = (v + (v[SUM_W-1] ? TRUNC_BIAS : SUM_W'(0))) >>> FRAC_BITS;
    if (t > lim)       c = lim;
    else if (t < -lim) c = -lim;
    else               c = t;
    return c[SPEED_W-1:0];
  endfunction

  always_comb begin
    lin_p = linear_velocity_i * $signed({1'b0, cfg_i.linear_gain});
    ang_p = angular_velocity_i * $signed({1'b0, cfg_i.angular_gain});
    diff  = SUM_W'(lin_p) - SUM_W'(ang_p);
    summ  = SUM_W'(lin_p) + SUM_W'(ang_p);
    lim_s = $signed(SUM_W'(cfg_i.speed_limit));
    left_goal_o  = to_goal(diff, lim_s);
    right_goal_o = to_goal(summ, lim_s);
  end

endmodule

// ===== sv/ddrh_wheel.sv =====
// ----------------------------------------------------------------------------
// ddrh_wheel
// One wheel: slew-limited step toward the target and H-bridge duty decode.
// ----------------------------------------------------------------------------
module ddrh_wheel (
  input  logic signed [ddrh_pkg::SPEED_W-1:0] cur_i,
  input  logic signed [ddrh_pkg::SPEED_W-1:0] goal_i,
  input  ddrh_pkg::cfg_t                      cfg_i,
  output logic signed [ddrh_pkg::SPEED_W-1:0] next_o,
  output logic [ddrh_pkg::DUTY_BITS-1:0]      fwd_duty_o,
  output logic [ddrh_pkg::DUTY_BITS-1:0]      rev_duty_o
);
  import ddrh_pkg::*;

  logic signed [RAMP_W-1:0] lim, cur, goal, gc, step, n, nc, mag;

  always_comb begin
    lim  = $signed(RAMP_W'(cfg_i.speed_limit));
    step = $signed(RAMP_W'(cfg_i.ramp_step));
    cur  = RAMP_W'(cur_i);
    goal = RAMP_W'(goal_i);

    // target re-clipped against the current limit
    if (goal > lim)       gc = lim;
    else if (goal < -lim) gc = -lim;
    else                  gc = goal;

    n = cur;
    if (cur < gc) begin
      n = cur + step;
      if (n > gc) n = gc;
    end else if (cur > gc) begin
      n = cur - step;
      if (n < gc) n = gc;
    end

    if (n > lim)       nc = lim;
    else if (n < -lim) nc = -lim;
    else               nc = n;

    next_o = nc[SPEED_W-1:0];
    mag    = -nc;

    // positive: forward, negative: reverse, zero: active brake
    if (nc > 0) begin
      fwd_duty_o = nc[DUTY_BITS-1:0];
      rev_duty_o = '0;
    end else if (nc < 0) begin
      fwd_duty_o = '0;
      rev_duty_o = mag[DUTY_BITS-1:0];
    end else begin
      fwd_duty_o = cfg_i.brake_duty;
      rev_duty_o = cfg_i.brake_duty;
    end
  end

endmodule

// ===== sv/diff_drive_ramp_hbridge_core.sv =====
// ----------------------------------------------------------------------------
// diff_drive_ramp_hbridge_core
// Differential-drive mixer with per-item slew limit and H-bridge duty output.
// ----------------------------------------------------------------------------
//  channel   | direction | handshake                 | payload
//  s_axis    | in        | s_axis_tvalid/tready      | tdata: lin, ang; tuser: operation
//  m_axis    | out       | m_axis_tvalid/tready      | tdata: duties, speeds, timed_out
//  apb       | in        | psel/penable/pwrite/pready| 6 regs at 4*i, 32b data
//
//  Each item is held in the input register, then the mixer, silence
//  counter and both wheel ramps run in one combinational pass into the result
//  register. Throughput: one item per cycle while m_axis is not stalled;
//  tvalid rises after the item has passed the input and result registers.
//  The wheel state updates in the same edge the result is registered, so
//  consecutive items see each other's state with no bubble.
//  A stalled m_axis holds the result; the input register still takes one item.
//  Reset (rst_ni, async low) clears state, valids and loads register defaults.
// ----------------------------------------------------------------------------
module diff_drive_ramp_hbridge_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // input items
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // [15:0] linear_velocity, [31:16] angular_velocity
  input  logic [ddrh_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  // [0] operation
  input  logic                               s_axis_tuser,
  // result items
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [7:0] left_fwd_duty, [15:8] left_rev_duty, [23:16] right_fwd_duty,
  // [31:24] right_rev_duty, [40:32] left_speed, [49:41] right_speed,
  // [50] timed_out, [55:51] zero
  output logic [ddrh_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  // configuration
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [ddrh_pkg::ADDR_W-1:0]        paddr,
  input  logic [ddrh_pkg::DATA_W-1:0]        pwdata,
  output logic [ddrh_pkg::DATA_W-1:0]        prdata,
  output logic                               pready
);
  import ddrh_pkg::*;

  // ---------------- configuration registers ----------------
  cfg_t                  cfg_q;
  logic                  cfg_we;
  logic [REG_IDX_W-1:0]  reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:2];
  assign cfg_we  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.linear_gain   <= RST_LINEAR_GAIN;
      cfg_q.angular_gain  <= RST_ANGULAR_GAIN;
      cfg_q.ramp_step     <= RST_RAMP_STEP;
      cfg_q.speed_limit   <= RST_SPEED_LIMIT;
      cfg_q.brake_duty    <= RST_BRAKE_DUTY;
      cfg_q.timeout_ticks <= RST_TIMEOUT_TICKS;
    end else if (cfg_we) begin
      unique case (reg_idx)
        REG_LINEAR_GAIN:   cfg_q.linear_gain   <= pwdata[GAIN_W-1:0];
        REG_ANGULAR_GAIN:  cfg_q.angular_gain  <= pwdata[GAIN_W-1:0];
        REG_RAMP_STEP:     cfg_q.ramp_step     <= pwdata[STEP_W-1:0];
        REG_SPEED_LIMIT:   cfg_q.speed_limit   <= pwdata[LIM_W-1:0];
        REG_BRAKE_DUTY:    cfg_q.brake_duty    <= pwdata[DUTY_BITS-1:0];
        REG_TIMEOUT_TICKS: cfg_q.timeout_ticks <= pwdata[CNT_W-1:0];
        default: ;  // unmapped: write ignored
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_LINEAR_GAIN:   prdata = DATA_W'(cfg_q.linear_gain);
      REG_ANGULAR_GAIN:  prdata = DATA_W'(cfg_q.angular_gain);
      REG_RAMP_STEP:     prdata = DATA_W'(cfg_q.ramp_step);
      REG_SPEED_LIMIT:   prdata = DATA_W'(cfg_q.speed_limit);
      REG_BRAKE_DUTY:    prdata = DATA_W'(cfg_q.brake_duty);
      REG_TIMEOUT_TICKS: prdata = DATA_W'(cfg_q.timeout_ticks);
      default:           prdata = '0;
    endcase
  end

  // ---------------- input register ----------------
  logic                      in_valid_q;
  logic                      op_q;
  logic signed [VEL_W-1:0]   lin_q, ang_q;
  logic                      out_valid_q;
  logic                      advance;

  // item moves from input register to result register
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      op_q  <= s_axis_tuser;
      lin_q <= $signed(s_axis_tdata[VEL_W-1:0]);
      ang_q <= $signed(s_axis_tdata[2*VEL_W-1:VEL_W]);
    end
  end

  // ---------------- state ----------------
  logic signed [SPEED_W-1:0] left_now_q, right_now_q, left_goal_q, right_goal_q;
  logic signed [SPEED_W-1:0] left_now_d, right_now_d, left_goal_d, right_goal_d;
  logic signed [SPEED_W-1:0] mix_left, mix_right;
  logic [CNT_W-1:0]          silence_q, silence_d, silence_inc;
  logic                      timed_d;

  ddrh_mix u_mix (
    .linear_velocity_i  (lin_q),
    .angular_velocity_i (ang_q),
    .cfg_i              (cfg_q),
    .left_goal_o        (mix_left),
    .right_goal_o       (mix_right)
  );

  // silence counter saturates at all-ones
  assign silence_inc = (silence_q == '1) ? silence_q : silence_q + CNT_W'(1);

  always_comb begin
    left_goal_d  = left_goal_q;
    right_goal_d = right_goal_q;
    silence_d    = silence_q;
    timed_d      = 1'b0;
    if (op_q == OP_COMMAND) begin
      left_goal_d  = mix_left;
      right_goal_d = mix_right;
      silence_d    = '0;
    end else begin
      silence_d = silence_inc;
      if (silence_inc >= cfg_q.timeout_ticks) begin
        left_goal_d  = '0;
        right_goal_d = '0;
        timed_d      = 1'b1;
      end
    end
  end

  logic [DUTY_BITS-1:0] lf_d, lr_d, rf_d, rr_d;

  ddrh_wheel u_left (
    .cur_i      (left_now_q),
    .goal_i     (left_goal_d),
    .cfg_i      (cfg_q),
    .next_o     (left_now_d),
    .fwd_duty_o (lf_d),
    .rev_duty_o (lr_d)
  );

  ddrh_wheel u_right (
    .cur_i      (right_now_q),
    .goal_i     (right_goal_d),
    .cfg_i      (cfg_q),
    .next_o     (right_now_d),
    .fwd_duty_o (rf_d),
    .rev_duty_o (rr_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_now_q   <= '0;
      right_now_q  <= '0;
      left_goal_q  <= '0;
      right_goal_q <= '0;
      silence_q    <= '0;
    end else if (advance) begin
      left_now_q   <= left_now_d;
      right_now_q  <= right_now_d;
      left_goal_q  <= left_goal_d;
      right_goal_q <= right_goal_d;
      silence_q    <= silence_d;
    end
  end

  // ---------------- result register ----------------
  logic [OUT_TDATA_W-1:0] out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= OUT_TDATA_W'({timed_d, right_now_d, left_now_d, rr_d, rf_d, lr_d, lf_d});
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule
